[rtl/core/integer_register_alu_unit_defines.svh]
// Assertion macros for the integer register ALU unit
`ifndef INTEGER_REGISTER_ALU_UNIT_DEFINES_SVH
`define INTEGER_REGISTER_ALU_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif
`endif

[rtl/core/ira_pkg.sv]
// Package: function codes, widths and shared types for the register ALU
`timescale 1ns / 1ps
package ira_pkg;
  localparam int unsigned RegCount = 32;
  localparam int unsigned RegAw    = $clog2(RegCount);
  localparam int unsigned XLen     = 32;
  localparam int unsigned CntW     = $clog2(XLen + 1);
  localparam logic [RegAw-1:0] RetReg = RegAw'(28);

  localparam logic [5:0] FnAdd   = 6'b100000;
  localparam logic [5:0] FnSub   = 6'b100010;
  localparam logic [5:0] FnMul   = 6'b011001;
  localparam logic [5:0] FnMulth = 6'b011000;
  localparam logic [5:0] FnDiv   = 6'b011010;
  localparam logic [5:0] FnRem   = 6'b011011;
  localparam logic [5:0] FnMov   = 6'b001001;
  localparam logic [5:0] FnIn    = 6'b101010;
  localparam logic [5:0] FnOut   = 6'b010101;
  localparam logic [5:0] FnJr    = 6'b001000;
  localparam logic [5:0] FnRetl  = 6'b111111;

  // iterative unit operation select
  typedef enum logic [1:0] {
    OpMul = 2'd0,
    OpDiv = 2'd1
  } iter_op_e;

  typedef struct packed {
    logic     start;
    iter_op_e op;
  } iter_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iter_sts_t;
endpackage

[rtl/core/ira_iter_unit.sv]
// Shared shift-add multiplier / restoring divider, one bit per cycle
`timescale 1ns / 1ps
`include "integer_register_alu_unit_defines.svh"
module ira_iter_unit
  import ira_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  iter_ctl_t       ctl_i,
  input  logic [XLen-1:0] a_i,
  input  logic [XLen-1:0] b_i,
  output iter_sts_t       sts_o,
  output logic [XLen-1:0] hi_o,
  output logic [XLen-1:0] lo_o
);
  logic            busy_q, busy_d, done_q, done_d;
  iter_op_e        op_q, op_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [XLen-1:0] hi_q, hi_d, lo_q, lo_d, b_q, b_d;
  logic [XLen:0]   sum, trial;

  // mul: {hi,lo} product, lo holds multiplier; div: hi rem, lo quotient
  assign sum   = {1'b0, hi_q} + (lo_q[0] ? {1'b0, b_q} : '0);
  assign trial = {hi_q, lo_q[XLen-1]} - {1'b0, b_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    b_d    = b_q;
    if (ctl_i.start && !busy_q) begin
      busy_d = 1'b1;
      op_d   = ctl_i.op;
      cnt_d  = CntW'(XLen);
      hi_d   = '0;
      lo_d   = a_i;
      b_d    = b_i;
    end else if (busy_q) begin
      if (op_q == OpMul) begin
        {hi_d, lo_d} = {sum, lo_q[XLen-1:1]};
      end else if (trial[XLen]) begin
        {hi_d, lo_d} = {hi_q[XLen-2:0], lo_q, 1'b0};
      end else begin
        hi_d = trial[XLen-1:0];
        lo_d = {lo_q[XLen-2:0], 1'b1};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OpMul;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
    lo_q <= lo_d;
    b_q  <= b_d;
  end

  assign sts_o = '{busy: busy_q, done: done_q};
  assign hi_o  = hi_q;
  assign lo_o  = lo_q;

  `ASSERT_IMPL(a_done_after_busy, done_q |-> $past(busy_q), "done without busy")
  `ASSERT_NEVER(a_busy_done, busy_q && done_q, "busy and done together")
  `ASSERT_IMPL(a_cnt_range, busy_q |-> (cnt_q != '0 && cnt_q <= CntW'(XLen)), "count range")
endmodule

[rtl/core/integer_register_alu_unit.sv]
// Top level: register file, decode sequencer and result register
//
// channel | valid        | stall        | payload
// in      | in_valid_i   | in_stall_o   | instr_i, in_value_i
// out     | out_valid_o  | out_stall_i  | jump_taken_o .. div_zero_o
//
// Simple ops (and div/rem by zero): the result is registered from the read state after accept.
// mul/multh/div/rem: accept, read state with start, 32 steps of the one-bit-per-cycle
// shared unit, done, writeback; no new item is accepted until the transaction is through.
// Reset clears the register file (flip-flops) and all control state.
// A held result blocks the next item: out_stall_i stalls input whenever a result is
// still waiting to be taken; input is also stalled outside the idle state.
`timescale 1ns / 1ps
`include "integer_register_alu_unit_defines.svh"
module integer_register_alu_unit
  import ira_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [31:0]     instr_i,
  input  logic [31:0]     in_value_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            jump_taken_o,
  output logic [31:0]     jump_target_o,
  output logic            out_byte_valid_o,
  output logic [7:0]      out_byte_o,
  output logic            div_zero_o
);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StIter = 2'd2;
  localparam logic [1:0] StDone = 2'd3;

  logic [1:0]      st_q, st_d;
  logic [31:0]     instr_q, inval_q;
  logic [XLen-1:0] rf_q [RegCount];
  logic [XLen-1:0] a_q, b_q, r28_q;
  logic            na_q, nb_q;
  iter_ctl_t       ctl;
  iter_sts_t       sts;
  logic [XLen-1:0] hi, lo;

  logic            ov_q;
  logic            o_jt_q, o_ov_q, o_dz_q;
  logic [31:0]     o_jtg_q;
  logic [7:0]      o_ob_q;

  logic [5:0]       fn;
  logic [RegAw-1:0] rs, rt, rd;
  logic             is_div, is_mul, b_zero;
  logic             we;
  logic [RegAw-1:0] wa;
  logic [XLen-1:0]  wd, ua, ub, q_s, r_s;
  logic             fin, jt;
  logic [31:0]      jtg;

  assign fn = instr_q[5:0];
  assign rs = instr_q[25:21];
  assign rt = instr_q[20:16];
  assign rd = instr_q[15:11];
  assign is_div = (fn == FnDiv) || (fn == FnRem);
  assign is_mul = (fn == FnMul) || (fn == FnMulth);
  assign b_zero = (b_q == '0);

  assign in_stall_o = (st_q != StIdle) || (ov_q && out_stall_i);

  assign ua = na_q ? (XLen'(0) - a_q) : a_q;
  assign ub = nb_q ? (XLen'(0) - b_q) : b_q;
  assign ctl.start = (st_q == StRead) && (is_mul || (is_div && !b_zero));
  assign ctl.op    = is_mul ? OpMul : OpDiv;

  ira_iter_unit u_iter (
    .clk_i, .rst_ni,
    .ctl_i (ctl),
    .a_i   (is_mul ? a_q : ua),
    .b_i   (is_mul ? b_q : ub),
    .sts_o (sts),
    .hi_o  (hi),
    .lo_o  (lo)
  );

  assign q_s = (na_q != nb_q) ? (XLen'(0) - lo) : lo;
  assign r_s = na_q ? (XLen'(0) - hi) : hi;

  // execute / writeback
  always_comb begin
    st_d = st_q;
    we   = 1'b0;
    wa   = rd;
    wd   = '0;
    fin  = 1'b0;
    jt   = 1'b0;
    jtg  = '0;
    case (st_q)
      StIdle: if (in_valid_i && !in_stall_o) st_d = StRead;
      StRead: begin
        if (ctl.start) begin
          st_d = StIter;
        end else begin
          st_d = StIdle;
          fin  = 1'b1;
          case (fn)
            FnAdd: begin we = 1'b1; wd = a_q + b_q; end
            FnSub: begin we = 1'b1; wd = a_q - b_q; end
            FnDiv: begin we = 1'b1; wd = '1; end
            FnRem: begin we = 1'b1; wd = a_q; end
            FnMov: begin we = 1'b1; wa = rt; wd = a_q; end
            FnIn:  begin we = 1'b1; wa = rs; wd = inval_q; end
            FnJr:  begin jt = 1'b1; jtg = a_q; end
            FnRetl: begin jt = 1'b1; jtg = r28_q; end
            default: ;
          endcase
        end
      end
      StIter: if (sts.done) st_d = StDone;
      StDone: begin
        st_d = StIdle;
        fin  = 1'b1;
        we   = 1'b1;
        case (fn)
          FnMul:   wd = lo;
          FnMulth: wd = hi;
          FnDiv:   wd = q_s;
          default: wd = r_s;
        endcase
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= StIdle;
      ov_q   <= 1'b0;
      o_jt_q <= 1'b0;
      o_ov_q <= 1'b0;
      o_dz_q <= 1'b0;
      o_jtg_q <= '0;
      o_ob_q <= '0;
      for (int i = 0; i < RegCount; i++) rf_q[i] <= '0;
    end else begin
      st_q <= st_d;
      if (we) rf_q[wa] <= wd;
      if (fin) begin
        ov_q    <= 1'b1;
        o_jt_q  <= jt;
        o_jtg_q <= jtg;
        o_ov_q  <= (fn == FnOut);
        o_ob_q  <= (fn == FnOut) ? a_q[7:0] : 8'h00;
        o_dz_q  <= is_div && b_zero;
      end else if (ov_q && !out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      instr_q <= instr_i;
      inval_q <= in_value_i;
    end
    if (st_q == StIdle) begin
      a_q   <= rf_q[instr_i[25:21]];
      b_q   <= rf_q[instr_i[20:16]];
      r28_q <= rf_q[RetReg];
      na_q  <= rf_q[instr_i[25:21]][XLen-1];
      nb_q  <= rf_q[instr_i[20:16]][XLen-1];
    end
  end

  assign out_valid_o      = ov_q;
  assign jump_taken_o     = o_jt_q;
  assign jump_target_o    = o_jtg_q;
  assign out_byte_valid_o = o_ov_q;
  assign out_byte_o       = o_ob_q;
  assign div_zero_o       = o_dz_q;

  `ASSERT_IMPL(a_start_from_read, ctl.start |-> st_q == StRead, "start outside read")
  `ASSERT_IMPL(a_iter_busy, (st_q == StIter && !sts.done) |-> sts.busy, "iter not busy")
  `ASSERT_NEVER(a_fin_pending, fin && ov_q && out_stall_i, "result overrun")
endmodule
